FILE: hw/rtl/hmp_pkg.sv
// ----------------------------------------------------------------------------
// hmp_pkg
// Shared types and constants for the hash message padder
// ----------------------------------------------------------------------------
package hmp_pkg;

  localparam int BLOCK_BYTES     = 64;
  localparam int POS_W           = $clog2(BLOCK_BYTES);
  localparam int IDX_W           = $clog2(2 * BLOCK_BYTES) + 1;
  localparam int CNT_FIELD_BYTES = 8;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [7:0] PAD_HIGH = 8'h80;
  localparam logic [7:0] PAD_LOW  = 8'h01;

  localparam logic [1:0] REG_PAD_HIGH_BIT      = 2'd0;
  localparam logic [1:0] REG_LENGTH_BIG_ENDIAN = 2'd1;
  localparam logic [1:0] REG_COUNT_BYTES       = 2'd2;

  localparam logic       OP_BYTE     = 1'b0;
  localparam logic       OP_FINALIZE = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] word;
    logic        block_last;
    logic        message_last;
  } out_t;

  typedef struct packed {
    logic       pad_high_bit;
    logic       length_big_endian;
    logic [4:0] count_bytes;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIN  = 2'b10
  } state_t;

  typedef struct packed {
    logic byte_en;
    logic fin_start;
    logic fin_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic beat_free;
    logic fin_last;
  } dp_status_t;

endpackage

FILE: hw/rtl/hmp_cfg.sv
// ----------------------------------------------------------------------------
// hmp_cfg
// APB register file: pad byte select, length byte order, count area size
// ----------------------------------------------------------------------------
module hmp_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hmp_pkg::ADDR_W-1:0] paddr,
  input  logic [hmp_pkg::DATA_W-1:0] pwdata,
  output logic [hmp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output hmp_pkg::cfg_t              cfg
);
  import hmp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pad_high_bit      <= 1'b1;
      cfg.length_big_endian <= 1'b1;
      cfg.count_bytes       <= 5'd8;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAD_HIGH_BIT:      cfg.pad_high_bit      <= pwdata[0];
        REG_LENGTH_BIG_ENDIAN: cfg.length_big_endian <= pwdata[0];
        REG_COUNT_BYTES:       cfg.count_bytes       <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAD_HIGH_BIT:      prdata = {{(DATA_W-1){1'b0}}, cfg.pad_high_bit};
      REG_LENGTH_BIG_ENDIAN: prdata = {{(DATA_W-1){1'b0}}, cfg.length_big_endian};
      REG_COUNT_BYTES:       prdata = {{(DATA_W-5){1'b0}}, cfg.count_bytes};
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/hmp_dp.sv
// ----------------------------------------------------------------------------
// hmp_dp
// Datapath: byte packing, length counter, pad and length word generation,
// output beat register
// ----------------------------------------------------------------------------
module hmp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  hmp_pkg::in_t         item,
  input  hmp_pkg::cfg_t        cfg,
  input  hmp_pkg::ctrl_cmd_t   cmd,
  output hmp_pkg::dp_status_t  status,
  input  logic                 beat_stall,
  output logic                 beat_valid,
  output hmp_pkg::out_t        beat
);
  import hmp_pkg::*;

  logic [POS_W-1:0] pos;
  logic [55:0]      partial;
  logic [60:0]      byte_count;
  logic [IDX_W-1:0] widx;
  logic             extra;

  logic [POS_W:0]   pos_inc;
  logic             blk_end;
  logic [IDX_W-1:0] cb_sat;
  logic             extra_next;
  logic [IDX_W-1:0] w0;
  logic [IDX_W-1:0] widx_inc;
  logic [IDX_W-1:0] total;
  logic             first_word;
  logic [2:0]       k;
  logic [6:0]       part_sh;
  logic [5:0]       pad_sh;
  logic [7:0]       pad_byte;
  logic [63:0]      bits;
  logic [63:0]      bits_le;
  logic [63:0]      fin_word;

  assign pos_inc  = {1'b0, pos} + (POS_W+1)'(1);
  assign blk_end  = (pos_inc == (POS_W+1)'(BLOCK_BYTES));
  assign w0       = IDX_W'({pos[POS_W-1:3], 3'b000});
  assign widx_inc = widx + IDX_W'(8);
  assign total    = extra ? IDX_W'(2 * BLOCK_BYTES) : IDX_W'(BLOCK_BYTES);
  assign first_word = (widx == w0);
  assign k        = pos[2:0];
  assign part_sh  = 7'((4'd8 - {1'b0, k}) << 3);
  assign pad_sh   = 6'((3'd7 - k) << 3);
  assign pad_byte = cfg.pad_high_bit ? PAD_HIGH : PAD_LOW;
  assign bits     = {byte_count, 3'b000};

  assign status.beat_free = !beat_valid || !beat_stall;
  assign status.fin_last  = (widx_inc == total);

  // saturate count area into 8..block size
  always_comb begin
    if (cfg.count_bytes < 5'(CNT_FIELD_BYTES)) begin
      cb_sat = IDX_W'(CNT_FIELD_BYTES);
    end else if (IDX_W'(cfg.count_bytes) > IDX_W'(BLOCK_BYTES)) begin
      cb_sat = IDX_W'(BLOCK_BYTES);
    end else begin
      cb_sat = IDX_W'(cfg.count_bytes);
    end
    extra_next = (IDX_W'(pos) + cb_sat) >= IDX_W'(BLOCK_BYTES);
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      bits_le[8*j +: 8] = bits[8*(7-j) +: 8];
    end
    if (first_word) begin
      fin_word = ({8'h00, partial} << part_sh) | ({56'h0, pad_byte} << pad_sh);
    end else if (status.fin_last) begin
      fin_word = cfg.length_big_endian ? bits : bits_le;
    end else begin
      fin_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      partial    <= '0;
      byte_count <= '0;
      widx       <= '0;
      extra      <= 1'b0;
      beat_valid <= 1'b0;
    end else begin
      if (!beat_stall) begin
        beat_valid <= 1'b0;
      end
      if (cmd.byte_en) begin
        byte_count <= byte_count + 61'd1;
        if (k == 3'd7) begin
          beat_valid        <= 1'b1;
          beat.word         <= {partial, item.data_byte};
          beat.block_last   <= blk_end;
          beat.message_last <= 1'b0;
          partial           <= '0;
          pos               <= blk_end ? '0 : pos_inc[POS_W-1:0];
        end else begin
          partial <= {partial[47:0], item.data_byte};
          pos     <= pos_inc[POS_W-1:0];
        end
      end
      if (cmd.fin_start) begin
        widx  <= w0;
        extra <= extra_next;
      end
      if (cmd.fin_emit) begin
        beat_valid        <= 1'b1;
        beat.word         <= fin_word;
        beat.block_last   <= (widx_inc == IDX_W'(BLOCK_BYTES)) ||
                             (widx_inc == IDX_W'(2 * BLOCK_BYTES));
        beat.message_last <= status.fin_last;
        widx              <= widx_inc;
        if (status.fin_last) begin
          pos        <= '0;
          partial    <= '0;
          byte_count <= '0;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/hmp_ctrl.sv
// ----------------------------------------------------------------------------
// hmp_ctrl
// Controller: takes message bytes, sequences the padding words on finalize
// ----------------------------------------------------------------------------
module hmp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_operation,
  output logic                item_stall,
  input  hmp_pkg::dp_status_t status,
  output hmp_pkg::ctrl_cmd_t  cmd
);
  import hmp_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign item_stall = (state != ST_IDLE) || !status.beat_free;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    state_next    = state;
    cmd.byte_en   = 1'b0;
    cmd.fin_start = 1'b0;
    cmd.fin_emit  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item_operation == OP_FINALIZE) begin
            cmd.fin_start = 1'b1;
            state_next    = ST_FIN;
          end else begin
            cmd.byte_en = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (status.beat_free) begin
          cmd.fin_emit = 1'b1;
          if (status.fin_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/hash_message_padder.sv
// ----------------------------------------------------------------------------
// hash_message_padder
// Merkle-Damgard message padding front end: packs bytes into 64-bit words,
// appends pad byte, zeros and the bit count
// ----------------------------------------------------------------------------
// a full word is registered with its eighth byte and appears in the next
// cycle, and bytes stream one per cycle while beats are taken
// finalize emits the rest of the block (plus one more if the pad lands in
// the count area) from the output register, one word per cycle unless stalled
// synchronous reset clears position, partial word, byte count and beat valid;
// registers return to pad 0x80, big-endian length, 8 count bytes
module hash_message_padder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  hmp_pkg::in_t               item,
  output logic                       beat_valid,
  input  logic                       beat_stall,
  output hmp_pkg::out_t              beat,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hmp_pkg::ADDR_W-1:0] paddr,
  input  logic [hmp_pkg::DATA_W-1:0] pwdata,
  output logic [hmp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import hmp_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  hmp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hmp_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_operation (item.operation),
    .item_stall     (item_stall),
    .status         (status),
    .cmd            (cmd)
  );

  hmp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .beat_stall (beat_stall),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

endmodule

FILE: hw/rtl/hmp_checker.sv
// ----------------------------------------------------------------------------
// hmp_checker
// Port-level checks for the hash message padder
// ----------------------------------------------------------------------------
module hmp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_stall,
  input hmp_pkg::in_t               item,
  input logic                       beat_valid,
  input logic                       beat_stall,
  input hmp_pkg::out_t              beat
);
  import hmp_pkg::*;

  // no beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !beat_valid)
    else $error("beat valid after reset");

  // stalled beat holds
  a_beat_hold: assert property (@(posedge clk) disable iff (rst)
    beat_valid && beat_stall |=> beat_valid && $stable(beat))
    else $error("stalled beat changed");

  // last word of a message always closes a block
  a_msg_block: assert property (@(posedge clk) disable iff (rst)
    beat_valid |-> !beat.message_last || beat.block_last)
    else $error("message end inside a block");

  // finalize blocks new input while padding words go out
  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == OP_FINALIZE |=> item_stall)
    else $error("input taken during finalize");

endmodule

bind hash_message_padder hmp_checker u_hmp_checker (.*);
